// File: hdl/vtb_pkg.sv
// Shared types and constants for the vertex transform and bounding box block.
package vtb_pkg;

   localparam int COORD_WIDTH_DEF = 32;   // default coordinate width
   localparam int SCALE_WIDTH     = 24;   // unsigned Q8.16 scale
   localparam int TRIG_WIDTH      = 18;   // signed Q2.16 cosine / sine
   localparam int OPB_WIDTH       = 25;   // signed multiplier B operand
   localparam int MUL_FRAC        = 16;   // fraction bits dropped per scale product or rotation sum
   localparam int REG_IDX_WIDTH   = 3;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);
   localparam logic [TRIG_WIDTH-1:0]  COS_RESET   = TRIG_WIDTH'(65536);

   typedef enum logic [REG_IDX_WIDTH-1:0] {
      REG_SCALE    = 3'd0,
      REG_OFFSET_X = 3'd1,
      REG_OFFSET_Y = 3'd2,
      REG_OFFSET_Z = 3'd3,
      REG_COS      = 3'd4,
      REG_SIN      = 3'd5
   } reg_idx_type;

   // Product schedule through the shared multiplier
   typedef enum logic [2:0] {
      STEP_SX = 3'd0,   // x * scale
      STEP_SY = 3'd1,   // y * scale
      STEP_SZ = 3'd2,   // z * scale
      STEP_XC = 3'd3,   // sx * cos
      STEP_YS = 3'd4,   // sy * sin
      STEP_XS = 3'd5,   // sx * sin
      STEP_YC = 3'd6    // sy * cos
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_WRAP
   } state_type;

   typedef struct packed {
      logic     issue;   // multiplier launch this cycle
      step_type step;    // which product
      logic     wrap;    // write result and update box
   } ctrl_type;

endpackage

// File: hdl/vtb_mul.sv
// Shared registered signed multiplier with a step tag carried alongside.
module vtb_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  vtb_pkg::step_type                   tag,
   input  logic signed [A_WIDTH-1:0]           op_a,
   input  logic signed [B_WIDTH-1:0]           op_b,
   output logic                                prod_valid,
   output vtb_pkg::step_type                   prod_tag,
   output logic signed [A_WIDTH+B_WIDTH-1:0]   prod
);
   import vtb_pkg::*;

   localparam int PW = A_WIDTH + B_WIDTH;

   logic signed [PW-1:0] prod_ff, prod_in;
   step_type             tag_ff;
   logic                 valid_ff;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
         tag_ff  <= tag;
      end
   end

   assign prod_valid = valid_ff;
   assign prod_tag   = tag_ff;
   assign prod       = prod_ff;

endmodule

// File: hdl/vtb_ctrl.sv
// Sequencer: walks the seven products of one vertex, then writes the result.
module vtb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   output vtb_pkg::ctrl_type ctrl
);
   import vtb_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SX;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = STEP_SX;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_type'(step_ff + 3'd1);
            if (step_ff == STEP_YC) begin
               state_in = ST_DRAIN;
               step_in  = STEP_SX;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      ctrl.issue = 1'b0;
      ctrl.step  = step_ff;
      ctrl.wrap  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready  = 1'b1;
         ST_MUL:   ctrl.issue = 1'b1;
         ST_DRAIN: ;
         ST_WRAP:  ctrl.wrap  = out_free;
         default:  ;
      endcase
   end

endmodule

// File: hdl/vtb_bbox.sv
// Running axis-aligned bounding box; empties after the last vertex of a model.
module vtb_bbox #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          last,
   input  logic signed [COORD_WIDTH-1:0] pt_x,
   input  logic signed [COORD_WIDTH-1:0] pt_y,
   input  logic signed [COORD_WIDTH-1:0] pt_z,
   output logic signed [COORD_WIDTH-1:0] min_x,
   output logic signed [COORD_WIDTH-1:0] max_x,
   output logic signed [COORD_WIDTH-1:0] min_y,
   output logic signed [COORD_WIDTH-1:0] max_y,
   output logic signed [COORD_WIDTH-1:0] min_z,
   output logic signed [COORD_WIDTH-1:0] max_z
);
   import vtb_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [COORD_WIDTH-1:0] min_ff [3];
   logic signed [COORD_WIDTH-1:0] max_ff [3];
   logic signed [COORD_WIDTH-1:0] pt     [3];
   logic signed [COORD_WIDTH-1:0] min_in [3];
   logic signed [COORD_WIDTH-1:0] max_in [3];

   assign pt[0] = pt_x;
   assign pt[1] = pt_y;
   assign pt[2] = pt_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         min_in[i] = (pt[i] < min_ff[i]) ? pt[i] : min_ff[i];
         max_in[i] = (pt[i] > max_ff[i]) ? pt[i] : max_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= POS_MAX;
            max_ff[i] <= NEG_MIN;
         end
      end else if (update) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= last ? POS_MAX : min_in[i];
            max_ff[i] <= last ? NEG_MIN : max_in[i];
         end
      end
   end

   // box including the current point
   assign min_x = min_in[0];
   assign max_x = max_in[0];
   assign min_y = min_in[1];
   assign max_y = max_in[1];
   assign min_z = min_in[2];
   assign max_z = max_in[2];

endmodule

// File: hdl/vertex_transform_bbox.sv
// Top level of the vertex transform with running bounding box.
//
// Takes one mesh vertex per transaction in signed fixed point (COORD_WIDTH
// bits, 16 fraction bits), scales it by the unsigned Q8.16 factor, adds the
// per-axis offset and saturates, then rotates x and y about z with the
// configured Q2.16 cosine and sine and saturates again; z is only scaled and
// offset. Every scale product drops 16 fraction bits rounding toward minus
// infinity, and each rotated coordinate is rounded once from the exact sum.
// Each result transaction carries the transformed vertex plus the box so far,
// including this vertex; box_final echoes last_vertex, and after that result
// the box goes back to empty. A vertex is accepted in idle; its seven
// products (three scale, four rotation) go one per cycle through the
// single shared multiplier, then the sequencer drains the multiplier's
// output register, writes the result register once the result side is
// free, and returns to idle, where the next vertex is accepted. A new
// vertex is not accepted until the previous one has been written. The
// result register is separate, so a new vertex is accepted while the
// previous result still waits. Configuration: csr_we with csr_addr 0..5
// (scale, offset_x, offset_y, offset_z, cos_angle, sin_angle); other
// indexes are ignored. Write only while the block is idle.
module vertex_transform_bbox #(
   parameter int COORD_WIDTH = vtb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration
   input  logic                                    csr_we,
   input  logic [vtb_pkg::REG_IDX_WIDTH-1:0]       csr_addr,
   input  logic [((COORD_WIDTH > vtb_pkg::SCALE_WIDTH) ?
                  COORD_WIDTH : vtb_pkg::SCALE_WIDTH)-1:0] csr_wdata,
   // vertex in
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [COORD_WIDTH-1:0]           req_x_in,
   input  logic signed [COORD_WIDTH-1:0]           req_y_in,
   input  logic signed [COORD_WIDTH-1:0]           req_z_in,
   input  logic                                    req_last_vertex,
   // result out
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [COORD_WIDTH-1:0]           rsp_x_out,
   output logic signed [COORD_WIDTH-1:0]           rsp_y_out,
   output logic signed [COORD_WIDTH-1:0]           rsp_z_out,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_max_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_min_z,
   output logic signed [COORD_WIDTH-1:0]           rsp_box_max_z,
   output logic                                    rsp_box_final
);
   import vtb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + OPB_WIDTH;   // full product width
   localparam int SW = PW + 1;           // sum of two products

   // saturation bounds in the wide domain
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   // ---------------- configuration registers ----------------
   logic        [SCALE_WIDTH-1:0] scale_ff;
   logic signed [CW-1:0]          off_x_ff, off_y_ff, off_z_ff;
   logic signed [TRIG_WIDTH-1:0]  cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
         cos_ff   <= COS_RESET;
         sin_ff   <= '0;
      end else if (csr_we) begin
         // out-of-range indexes fall through and are dropped
         unique case (csr_addr)
            REG_SCALE:    scale_ff <= csr_wdata[SCALE_WIDTH-1:0];
            REG_OFFSET_X: off_x_ff <= csr_wdata[CW-1:0];
            REG_OFFSET_Y: off_y_ff <= csr_wdata[CW-1:0];
            REG_OFFSET_Z: off_z_ff <= csr_wdata[CW-1:0];
            REG_COS:      cos_ff   <= csr_wdata[TRIG_WIDTH-1:0];
            REG_SIN:      sin_ff   <= csr_wdata[TRIG_WIDTH-1:0];
            default:      ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   ctrl_type ctrl;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   vtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // ---------------- input capture ----------------
   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic                 last_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff    <= req_x_in;
         y_ff    <= req_y_in;
         z_ff    <= req_z_in;
         last_ff <= req_last_vertex;
      end
   end

   // ---------------- shared multiplier ----------------
   logic signed [CW-1:0]        sx_ff, sy_ff;
   logic signed [CW-1:0]        op_a;
   logic signed [OPB_WIDTH-1:0] op_b;
   logic signed [OPB_WIDTH-1:0] scale_b, cos_b, sin_b;

   assign scale_b = signed'({1'b0, scale_ff});
   assign cos_b   = OPB_WIDTH'(cos_ff);
   assign sin_b   = OPB_WIDTH'(sin_ff);

   always_comb begin
      unique case (ctrl.step)
         STEP_SX: begin op_a = x_ff;  op_b = scale_b; end
         STEP_SY: begin op_a = y_ff;  op_b = scale_b; end
         STEP_SZ: begin op_a = z_ff;  op_b = scale_b; end
         STEP_XC: begin op_a = sx_ff; op_b = cos_b;   end
         STEP_YS: begin op_a = sy_ff; op_b = sin_b;   end
         STEP_XS: begin op_a = sx_ff; op_b = sin_b;   end
         STEP_YC: begin op_a = sy_ff; op_b = cos_b;   end
         default: begin op_a = x_ff;  op_b = scale_b; end
      endcase
   end

   logic                 prod_valid;
   step_type             prod_tag;
   logic signed [PW-1:0] prod;

   vtb_mul #(
      .A_WIDTH (CW),
      .B_WIDTH (OPB_WIDTH)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .issue      (ctrl.issue),
      .tag        (ctrl.step),
      .op_a       (op_a),
      .op_b       (op_b),
      .prod_valid (prod_valid),
      .prod_tag   (prod_tag),
      .prod       (prod)
   );

   // ---------------- post-multiply: offset / combine, floor, saturate ----------------
   logic signed [SW-1:0] acc_ff;     // first rotation product, kept exact
   logic signed [SW-1:0] prod_w;
   logic signed [SW-1:0] pre;        // value before saturation
   logic signed [CW-1:0] sat_val;
   logic signed [CW-1:0] xr_ff, yr_ff, zr_ff;

   assign prod_w = SW'(prod);

   always_comb begin
      unique case (prod_tag)
         STEP_SX: pre = (prod_w >>> MUL_FRAC) + SW'(off_x_ff);
         STEP_SY: pre = (prod_w >>> MUL_FRAC) + SW'(off_y_ff);
         STEP_SZ: pre = (prod_w >>> MUL_FRAC) + SW'(off_z_ff);
         STEP_YS: pre = (acc_ff - prod_w) >>> MUL_FRAC;   // x*cos - y*sin
         STEP_YC: pre = (acc_ff + prod_w) >>> MUL_FRAC;   // x*sin + y*cos
         default: pre = prod_w;                           // accumulator loads
      endcase
   end

   always_comb begin
      if (pre > SAT_HI) begin
         sat_val = SAT_HI[CW-1:0];
      end else if (pre < SAT_LO) begin
         sat_val = SAT_LO[CW-1:0];
      end else begin
         sat_val = pre[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (prod_valid) begin
         unique case (prod_tag)
            STEP_SX: sx_ff  <= sat_val;
            STEP_SY: sy_ff  <= sat_val;
            STEP_SZ: zr_ff  <= sat_val;
            STEP_XC: acc_ff <= prod_w;
            STEP_YS: xr_ff  <= sat_val;
            STEP_XS: acc_ff <= prod_w;
            STEP_YC: yr_ff  <= sat_val;
            default: ;
         endcase
      end
   end

   // ---------------- bounding box ----------------
   logic signed [CW-1:0] bmin_x, bmax_x, bmin_y, bmax_y, bmin_z, bmax_z;

   vtb_bbox #(
      .COORD_WIDTH (CW)
   ) u_bbox (
      .clock  (clock),
      .reset  (reset),
      .update (ctrl.wrap),
      .last   (last_ff),
      .pt_x   (xr_ff),
      .pt_y   (yr_ff),
      .pt_z   (zr_ff),
      .min_x  (bmin_x),
      .max_x  (bmax_x),
      .min_y  (bmin_y),
      .max_y  (bmax_y),
      .min_z  (bmin_z),
      .max_z  (bmax_z)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctrl.wrap) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic signed [CW-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic signed [CW-1:0] out_min_x_ff, out_max_x_ff;
   logic signed [CW-1:0] out_min_y_ff, out_max_y_ff;
   logic signed [CW-1:0] out_min_z_ff, out_max_z_ff;
   logic                 out_final_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wrap) begin
         out_x_ff     <= xr_ff;
         out_y_ff     <= yr_ff;
         out_z_ff     <= zr_ff;
         out_min_x_ff <= bmin_x;
         out_max_x_ff <= bmax_x;
         out_min_y_ff <= bmin_y;
         out_max_y_ff <= bmax_y;
         out_min_z_ff <= bmin_z;
         out_max_z_ff <= bmax_z;
         out_final_ff <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_out     = out_x_ff;
   assign rsp_y_out     = out_y_ff;
   assign rsp_z_out     = out_z_ff;
   assign rsp_box_min_x = out_min_x_ff;
   assign rsp_box_max_x = out_max_x_ff;
   assign rsp_box_min_y = out_min_y_ff;
   assign rsp_box_max_y = out_max_y_ff;
   assign rsp_box_min_z = out_min_z_ff;
   assign rsp_box_max_z = out_max_z_ff;
   assign rsp_box_final = out_final_ff;

endmodule

// File: test/tb.sv
// Self-checking testbench for vertex_transform_bbox: transform and box prediction, random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vtb_pkg::*;

   localparam int CW            = COORD_WIDTH_DEF;
   localparam int CSR_W         = (CW > SCALE_WIDTH) ? CW : SCALE_WIDTH;
   localparam int REG_SLOTS     = 1 << REG_IDX_WIDTH;   // includes the unused indexes
   localparam int RESET_CYCLES  = 10;
   localparam int DRAIN_CYCLES  = 12;     // a bit over one vertex time of the block
   localparam int STALL_LIMIT   = 2000;   // cycles with no transaction before giving up
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 80;

   typedef logic signed [CW-1:0]         coord_t;
   typedef logic signed [TRIG_WIDTH-1:0] trig_t;

   localparam coord_t CMAX     = {1'b0, {(CW-1){1'b1}}};
   localparam coord_t CMIN     = {1'b1, {(CW-1){1'b0}}};
   localparam coord_t ONE      = coord_t'(65536);            // 1.0 in Q16.16
   localparam trig_t  TRIG_MAX = {1'b0, {(TRIG_WIDTH-1){1'b1}}};
   localparam trig_t  TRIG_MIN = {1'b1, {(TRIG_WIDTH-1){1'b0}}};

   // one result transaction: x, y, z, then min/max per axis, then the final flag
   typedef struct {
      coord_t field [9];
      logic   box_final;
   } vertex_result_t;

   // receiver pacing styles
   typedef enum int {
      PACE_OPEN,
      PACE_COIN,
      PACE_HOLD,
      PACE_MOSTLY
   } pace_mode_t;

   // Tracks the register settings and the running box, predicts each result
   // when its vertex is accepted, and checks results in order.
   class vertex_scoreboard;
      logic [SCALE_WIDTH-1:0] scale;
      coord_t                 offset [3];
      trig_t                  cos_q;
      trig_t                  sin_q;
      coord_t                 box_lo [3];
      coord_t                 box_hi [3];
      vertex_result_t         pending_vertices [$];
      string                  label [9];
      int                     mismatches;
      int                     checked;
      int                     noted;
      int                     models;
      int                     saturated;

      function new();
         label = '{"x_out", "y_out", "z_out", "box_min_x", "box_max_x",
                   "box_min_y", "box_max_y", "box_min_z", "box_max_z"};
         scale = SCALE_RESET;
         offset = '{0, 0, 0};
         cos_q = COS_RESET;
         sin_q = '0;
         empty_box();
         mismatches = 0;
         checked = 0;
         noted = 0;
         models = 0;
         saturated = 0;
      endfunction

      function void empty_box();
         for (int a = 0; a < 3; a++) begin
            box_lo[a] = CMAX;
            box_hi[a] = CMIN;
         end
      endfunction

      function coord_t clamp(longint v);
         if (v > longint'(CMAX)) return CMAX;
         if (v < longint'(CMIN)) return CMIN;
         return coord_t'(v);
      endfunction

      function void set_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            REG_SCALE:    scale = data[SCALE_WIDTH-1:0];
            REG_OFFSET_X: offset[0] = coord_t'(data[CW-1:0]);
            REG_OFFSET_Y: offset[1] = coord_t'(data[CW-1:0]);
            REG_OFFSET_Z: offset[2] = coord_t'(data[CW-1:0]);
            REG_COS:      cos_q = trig_t'(data[TRIG_WIDTH-1:0]);
            REG_SIN:      sin_q = trig_t'(data[TRIG_WIDTH-1:0]);
            default:      ;   // unused index, write dropped
         endcase
      endfunction

      function void note_vertex(coord_t x, coord_t y, coord_t z, logic last);
         coord_t         sx;
         coord_t         sy;
         vertex_result_t r;
         // scale (floor), shift, clamp before the rotation
         sx = clamp(((longint'(x) * longint'(scale)) >>> MUL_FRAC) + longint'(offset[0]));
         sy = clamp(((longint'(y) * longint'(scale)) >>> MUL_FRAC) + longint'(offset[1]));
         r.field[2] =
            clamp(((longint'(z) * longint'(scale)) >>> MUL_FRAC) + longint'(offset[2]));
         // rotated sums are exact, rounded once toward minus infinity, clamped again
         r.field[0] = clamp((longint'(sx) * longint'(cos_q) -
                             longint'(sy) * longint'(sin_q)) >>> MUL_FRAC);
         r.field[1] = clamp((longint'(sx) * longint'(sin_q) +
                             longint'(sy) * longint'(cos_q)) >>> MUL_FRAC);
         for (int a = 0; a < 3; a++) begin
            if (r.field[a] < box_lo[a]) box_lo[a] = r.field[a];
            if (r.field[a] > box_hi[a]) box_hi[a] = r.field[a];
            r.field[3 + 2*a] = box_lo[a];
            r.field[4 + 2*a] = box_hi[a];
            if (r.field[a] == CMAX || r.field[a] == CMIN) saturated++;
         end
         r.box_final = last;
         pending_vertices.push_back(r);
         noted++;
         // last vertex still reports the full box; the next one starts empty
         if (last) begin
            empty_box();
            models++;
         end
      endfunction

      function void check_result(vertex_result_t got);
         vertex_result_t want;
         if (pending_vertices.size() == 0) begin
            $error("result transaction with no vertex outstanding");
            mismatches++;
            return;
         end
         want = pending_vertices.pop_front();
         for (int i = 0; i < 9; i++) begin
            if (got.field[i] !== want.field[i]) begin
               $error("%s: expected %0d, got %0d", label[i], want.field[i], got.field[i]);
               mismatches++;
            end
         end
         if (got.box_final !== want.box_final) begin
            $error("box_final: expected %0d, got %0d", want.box_final, got.box_final);
            mismatches++;
         end
         checked++;
      endfunction

      function void flush_leftover();
         if (pending_vertices.size() != 0) begin
            $error("%0d result transactions never arrived", pending_vertices.size());
            mismatches += pending_vertices.size();
         end
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // block inputs, all known from time zero
   logic                     csr_we    = 1'b0;
   logic [REG_IDX_WIDTH-1:0] csr_addr  = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;
   logic                     req_valid = 1'b0;
   coord_t                   req_x_in  = '0;
   coord_t                   req_y_in  = '0;
   coord_t                   req_z_in  = '0;
   logic                     req_last_vertex = 1'b0;
   logic                     rsp_ready = 1'b0;

   // block outputs
   logic   req_ready;
   logic   rsp_valid;
   coord_t rsp_x_out;
   coord_t rsp_y_out;
   coord_t rsp_z_out;
   coord_t rsp_box_min_x;
   coord_t rsp_box_max_x;
   coord_t rsp_box_min_y;
   coord_t rsp_box_max_y;
   coord_t rsp_box_min_z;
   coord_t rsp_box_max_z;
   logic   rsp_box_final;

   vertex_scoreboard board = new();

   int             burst_left = 0;       // vertices left in the current sender burst
   int             settings_loaded = 0;
   int             pace_left = 0;
   pace_mode_t     pace_mode = PACE_OPEN;
   vertex_result_t rsp_seen;

   vertex_transform_bbox #(
      .COORD_WIDTH (CW)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_x_in        (req_x_in),
      .req_y_in        (req_y_in),
      .req_z_in        (req_z_in),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_z_out       (rsp_z_out),
      .rsp_box_min_x   (rsp_box_min_x),
      .rsp_box_max_x   (rsp_box_max_x),
      .rsp_box_min_y   (rsp_box_min_y),
      .rsp_box_max_y   (rsp_box_max_y),
      .rsp_box_min_z   (rsp_box_min_z),
      .rsp_box_max_z   (rsp_box_max_z),
      .rsp_box_final   (rsp_box_final)
   );

   // ---------------------------------------------------------------------------
   // Random value pickers
   // ---------------------------------------------------------------------------

   // mostly mesh-like coordinates, with full-range values and the range edges mixed in
   function automatic coord_t rand_coord();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick == 0) return CMAX;
      if (pick == 1) return CMIN;
      if (pick == 2) return coord_t'(-1);
      if (pick < 5) return coord_t'($urandom);
      // within +-1000.0
      return coord_t'(int'($urandom_range(0, 131072000)) - 65536000);
   endfunction

   function automatic coord_t rand_offset();
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) return '0;                 // origin shift turned off
      if (pick == 1) return coord_t'($urandom);
      return coord_t'(int'($urandom_range(0, 65536000)) - 32768000);   // +-500.0
   endfunction

   function automatic logic [SCALE_WIDTH-1:0] rand_scale();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      if (pick == 2) return SCALE_WIDTH'($urandom);
      return SCALE_WIDTH'($urandom_range(16384, 262144));   // 0.25 .. 4.0
   endfunction

   // true rotations most of the time, raw and extreme trig values now and then
   task automatic pick_rotation(output trig_t c, output trig_t s);
      real ang;
      int  pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
         c = trig_t'($urandom);
         s = trig_t'($urandom);
      end else if (pick == 1) begin
         c = $urandom_range(0, 1) ? TRIG_MAX : TRIG_MIN;
         s = $urandom_range(0, 1) ? TRIG_MAX : TRIG_MIN;
      end else begin
         ang = $urandom_range(0, 3599) * 3.141592653589793 / 1800.0;
         c = trig_t'($rtoi($cos(ang) * 65536.0));
         s = trig_t'($rtoi($sin(ang) * 65536.0));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Writes all six registers, then junk to the unused indexes (must be dropped).
   // Upper data bits above the scale and trig register widths carry random junk as well.
   task automatic load_settings(input logic [SCALE_WIDTH-1:0] scl, input coord_t ox,
                                input coord_t oy, input coord_t oz,
                                input trig_t cs, input trig_t sn);
      logic [CSR_W-1:0]         word [REG_SLOTS];
      logic [REG_IDX_WIDTH-1:0] idx;
      for (int i = 0; i < REG_SLOTS; i++) word[i] = $urandom;
      word[REG_SCALE][SCALE_WIDTH-1:0] = scl;
      word[REG_OFFSET_X][CW-1:0]       = ox;
      word[REG_OFFSET_Y][CW-1:0]       = oy;
      word[REG_OFFSET_Z][CW-1:0]       = oz;
      word[REG_COS][TRIG_WIDTH-1:0]    = cs;
      word[REG_SIN][TRIG_WIDTH-1:0]    = sn;
      for (int i = 0; i < REG_SLOTS; i++) begin
         idx = REG_IDX_WIDTH'(i);
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= word[i];
         @(posedge clock);
         board.set_reg(idx, word[i]);
      end
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // One vertex transaction. Bursts of random length; between bursts valid
   // drops for a random gap (a zero gap keeps valid high across the boundary).
   task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                              input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      req_valid       <= 1'b1;
      req_x_in        <= x;
      req_y_in        <= y;
      req_z_in        <= z;
      req_last_vertex <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_vertex(x, y, z, last);
      burst_left--;
   endtask

   // Sender holds off until every outstanding result has come back, then lets
   // the block settle; used before register writes and at the end.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver pacing: switches among open, coin-flip, hard stall and mostly-ready
   // stretches of random length
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (pace_left == 0) begin
         pace_mode = pace_mode_t'($urandom_range(0, 3));
         pace_left = $urandom_range(1, 40);
      end
      pace_left--;
      case (pace_mode)
         PACE_OPEN: rsp_ready <= 1'b1;
         PACE_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         PACE_HOLD: rsp_ready <= 1'b0;
         default:   rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Result monitor: every accepted result transaction is checked in order
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.field[0] = rsp_x_out;
         rsp_seen.field[1] = rsp_y_out;
         rsp_seen.field[2] = rsp_z_out;
         rsp_seen.field[3] = rsp_box_min_x;
         rsp_seen.field[4] = rsp_box_max_x;
         rsp_seen.field[5] = rsp_box_min_y;
         rsp_seen.field[6] = rsp_box_max_y;
         rsp_seen.field[7] = rsp_box_min_z;
         rsp_seen.field[8] = rsp_box_max_z;
         rsp_seen.box_final = rsp_box_final;
         board.check_result(rsp_seen);
      end
   end

   // Watchdog: ends the run once nothing has moved for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) stuck = 0;
         else stuck++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [SCALE_WIDTH-1:0] scl;
      trig_t                  cs;
      trig_t                  sn;
      int                     sent;
      int                     len;
      logic                   last;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: identity transform, empty box
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(CMAX, CMIN, CMAX, 1'b0);
      send_vertex(CMIN, CMAX, CMIN, 1'b0);
      send_vertex(-1, 1, -1, 1'b1);                     // closes the model, full box shown
      send_vertex(ONE, -ONE, coord_t'(32'sh0001_8000), 1'b0);   // box starts over
      wait_drained();

      // Largest scale with extreme offsets: first stage clamps; trig at the extremes
      load_settings('1, CMAX, CMIN, CMAX, TRIG_MIN, TRIG_MAX);
      send_vertex(CMAX, CMAX, CMAX, 1'b0);
      send_vertex(CMIN, CMIN, CMIN, 1'b0);
      send_vertex(ONE, -ONE, 3, 1'b0);
      send_vertex(-3, 5, -7, 1'b1);
      wait_drained();

      // Zero scale leaves only the offsets; non-unit cosine and sine, swapped extremes
      load_settings('0, CMIN, CMAX, CMIN, TRIG_MAX, TRIG_MIN);
      send_vertex(CMAX, CMIN, 123, 1'b0);
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1);
      wait_drained();

      // Just above unit scale, odd offsets, minus 45 degrees: low bits stress the
      // single floor rounding of the rotation sums
      load_settings(SCALE_WIDTH'(65537), 3, -5, 7, trig_t'(46341), trig_t'(-46341));
      send_vertex(1, -1, -1, 1'b0);
      send_vertex(-3, 2, 5, 1'b0);
      send_vertex(coord_t'(32'sh0000_7FFF), coord_t'(32'shFFFF_8001), 0, 1'b0);
      send_vertex(-1, -1, -1, 1'b1);
      wait_drained();

      // Scale 2.0 and cosine -2.0: second stage overflows and clamps
      load_settings(SCALE_WIDTH'(131072), 0, 0, 0, TRIG_MIN, TRIG_MAX);
      send_vertex(CMIN, CMAX, 0, 1'b0);
      send_vertex(CMAX, CMIN, 0, 1'b0);
      send_vertex(CMIN, CMIN, CMIN, 1'b1);
      wait_drained();

      // Random phases: new settings each time, mostly whole models of random
      // length, with stray last flags inside some models as noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick_rotation(cs, sn);
         scl = rand_scale();
         load_settings(scl, rand_offset(), rand_offset(), rand_offset(), cs, sn);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       len = 1;
               1:       len = $urandom_range(31, 60);
               default: len = $urandom_range(2, 30);
            endcase
            for (int k = 0; k < len; k++) begin
               last = (k == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
               send_vertex(rand_coord(), rand_coord(), rand_coord(), last);
            end
            sent += len;
         end
         wait_drained();
      end

      board.flush_leftover();
      $display("summary: %0d vertices in %0d models under %0d register settings",
               board.noted, board.models, settings_loaded + 1);
      $display("summary: %0d results checked, %0d coordinates at the range limits",
               board.checked, board.saturated);
      if (board.mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// File: vertex_transform_bbox.f
hdl/vtb_pkg.sv
hdl/vtb_mul.sv
hdl/vtb_ctrl.sv
hdl/vtb_bbox.sv
hdl/vertex_transform_bbox.sv
test/tb.sv
